// File: sv/bpe_pkg.sv
// bpe_pkg: shared types and constants for the bezier point evaluator
// no dependencies; imported by the interfaces, the cell and the top level
`default_nettype none

package bpe_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned T_W     = 17;
  localparam int unsigned CFG_W   = 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [T_W-1:0]     tparam_t;
  typedef logic        [CFG_W-1:0]   count_t;

  localparam tparam_t T_ONE              = 17'd65536;
  localparam count_t  POINT_COUNT_RESET  = 5'd4;
  localparam logic    MODE_LOAD          = 1'b0;
  localparam logic    MODE_EVAL          = 1'b1;

  typedef struct packed {
    logic    copy;
    logic    step;
    tparam_t t;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/bpe_in_if.sv
// bpe_in_if: input channel carrying load and evaluate transactions
// depends on bpe_pkg
`default_nettype none

interface bpe_in_if
  import bpe_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    mode;
  logic    [3:0] point_index;
  coord_t  point_x;
  coord_t  point_y;
  tparam_t t_value;

  modport source (output valid, mode, point_index, point_x, point_y, t_value, input ready);
  modport sink   (input valid, mode, point_index, point_x, point_y, t_value, output ready);
endinterface

`default_nettype wire

// File: sv/bpe_out_if.sv
// bpe_out_if: output channel carrying evaluated curve points
// depends on bpe_pkg
`default_nettype none

interface bpe_out_if
  import bpe_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t curve_x;
  coord_t curve_y;

  modport source (output valid, curve_x, curve_y, input ready);
  modport sink   (input valid, curve_x, curve_y, output ready);
endinterface

`default_nettype wire

// File: sv/bezier_point_evaluator_core.sv
// bezier_point_evaluator_core: de casteljau curve evaluator built as a row of cells
// depends on bpe_pkg, bpe_in_if, bpe_out_if and bpe_cell
//
// usage
//   in_i carries transactions: mode load writes control point point_index
//   (point_x, point_y) and gives no result; mode eval brings t_value (Q1.16,
//   65536 is 1.0, larger values clip to 1.0) and gives one transaction on out_o
//   cfg_we_i / cfg_wdata_i write point_count; the user must write it only while
//   the block is idle (not enforced by the block); an evaluate copies the
//   control points, runs point_count-1 interpolation rounds (one round a cycle
//   across the whole cell row) and moves working point 0 into the output
//   register, with point_count taken as 1 when zero and clipped to MAX_POINTS
//   in_i.ready is low from the cycle after an evaluate is taken until its
//   result has entered the output register
//   the output register holds the result while out_o.ready is low; loads and a
//   new evaluate are still taken, and a finished evaluate waits for the register
//   reset returns the controller to idle, empties the output register and sets
//   point_count to 4; control points are undefined until loaded
`default_nettype none

module bezier_point_evaluator_core
  import bpe_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire count_t      cfg_wdata_i,
  bpe_in_if.sink           in_i,
  bpe_out_if.source        out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_q, state_d;
  count_t           count_q;
  logic [CNT_W-1:0] rounds_q, rounds_d, rounds_init;
  tparam_t          t_q, t_d;
  logic             out_valid_q, out_valid_d;
  coord_t           out_x_q, out_y_q;
  logic             in_fire, eval_fire, finish;
  cell_ctrl_t       ctrl;

  coord_t work_x [MAX_POINTS];
  coord_t work_y [MAX_POINTS];

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign eval_fire  = in_fire && (in_i.mode == MODE_EVAL);
  assign finish     = (state_q == ST_RUN) && (rounds_q == '0) &&
                      (!out_valid_q || out_o.ready);

  always_comb begin
    if (count_q == '0) begin
      rounds_init = '0;
    end else if (32'(count_q) > MAX_POINTS) begin
      rounds_init = CNT_W'(MAX_POINTS - 1);
    end else begin
      rounds_init = CNT_W'(count_q - 5'd1);
    end
  end

  always_comb begin
    state_d     = state_q;
    rounds_d    = rounds_q;
    t_d         = t_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (eval_fire) begin
          state_d  = ST_RUN;
          rounds_d = rounds_init;
          t_d      = (in_i.t_value > T_ONE) ? T_ONE : in_i.t_value;
        end
      end
      ST_RUN: begin
        if (rounds_q != '0) begin
          rounds_d = rounds_q - 1'b1;
        end else if (finish) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ctrl.copy = eval_fire;
  assign ctrl.step = (state_q == ST_RUN) && (rounds_q != '0);
  assign ctrl.t    = t_q;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic   load_en;
    coord_t nx, ny;
    assign load_en = in_fire && (in_i.mode == MODE_LOAD) && (int'(in_i.point_index) == i);
    if (i == MAX_POINTS - 1) begin : g_last
      assign nx = work_x[i];
      assign ny = work_y[i];
    end else begin : g_mid
      assign nx = work_x[i+1];
      assign ny = work_y[i+1];
    end
    bpe_cell u_cell (
      .clk_i     (clk_i),
      .load_en_i (load_en),
      .load_x_i  (in_i.point_x),
      .load_y_i  (in_i.point_y),
      .ctrl_i    (ctrl),
      .next_x_i  (nx),
      .next_y_i  (ny),
      .work_x_o  (work_x[i]),
      .work_y_o  (work_y[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= POINT_COUNT_RESET;
      rounds_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rounds_q    <= rounds_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    if (finish) begin
      out_x_q <= work_x[0];
      out_y_q <= work_y[0];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.curve_x = out_x_q;
  assign out_o.curve_y = out_y_q;

endmodule

`default_nettype wire

// File: sv/bpe_cell.sv
// bpe_cell: one control point slot plus one working point with its interpolator
// depends on bpe_pkg; instantiated in a row by bezier_point_evaluator_core
`default_nettype none

module bpe_cell
  import bpe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       load_en_i,
  input  wire coord_t     load_x_i,
  input  wire coord_t     load_y_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire coord_t     next_x_i,
  input  wire coord_t     next_y_i,
  output coord_t          work_x_o,
  output coord_t          work_y_o
);

  coord_t ctl_x_q, ctl_y_q;
  coord_t work_x_q, work_x_d;
  coord_t work_y_q, work_y_d;
  coord_t lerp_x, lerp_y;

  function automatic coord_t lerp(coord_t a, coord_t b, tparam_t t);
    logic signed [16:0] diff;
    logic signed [35:0] prod;
    logic signed [35:0] sum;
    logic signed [19:0] q;
    coord_t             res;
    diff = 17'(b) - 17'(a);
    prod = 36'($signed({1'b0, t}) * diff);
    sum  = {{4{a[15]}}, a, 16'd0} + prod + 36'sd32768;
    q    = 20'(sum >>> 16);
    if (q > 20'sd32767) begin
      res = 16'sh7fff;
    end else if (q < -20'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = q[15:0];
    end
    return res;
  endfunction

  assign lerp_x = lerp(work_x_q, next_x_i, ctrl_i.t);
  assign lerp_y = lerp(work_y_q, next_y_i, ctrl_i.t);

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      ctl_x_q <= load_x_i;
      ctl_y_q <= load_y_i;
    end
  end

  always_comb begin
    work_x_d = work_x_q;
    work_y_d = work_y_q;
    if (ctrl_i.copy) begin
      work_x_d = ctl_x_q;
      work_y_d = ctl_y_q;
    end else if (ctrl_i.step) begin
      work_x_d = lerp_x;
      work_y_d = lerp_y;
    end
  end

  always_ff @(posedge clk_i) begin
    work_x_q <= work_x_d;
    work_y_q <= work_y_d;
  end

  assign work_x_o = work_x_q;
  assign work_y_o = work_y_q;

endmodule

`default_nettype wire

// File: bench/bezier_point_evaluator_checker.sv
`timescale 1ns / 1ps
// bezier_point_evaluator_checker: watches the register port and both channels,
// predicts every evaluated curve point and compares it with the block's output
// depends on bpe_pkg, bpe_in_if and bpe_out_if

module bezier_point_evaluator_checker
  import bpe_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire count_t cfg_wdata_i,
  bpe_in_if           in_mon_i,
  bpe_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned points_due_o
);

  typedef struct packed {
    coord_t x;
    coord_t y;
  } curve_point_t;

  count_t       point_count = POINT_COUNT_RESET;
  coord_t       ctrl_x [MAX_POINTS];
  coord_t       ctrl_y [MAX_POINTS];
  curve_point_t curve_points_due [$];
  int unsigned  mismatches = 0;
  int unsigned  due_count  = 0;

  assign fail_count_o = mismatches;
  assign points_due_o = due_count;

  function automatic coord_t lerp_coord(coord_t a, coord_t b, tparam_t t);
    longint acc;
    longint q;
    acc = (longint'(T_ONE) - longint'(t)) * longint'(a) + longint'(t) * longint'(b);
    q = (acc + 64'sd32768) >>> 16;
    if (q > 64'sd32767) q = 64'sd32767;
    if (q < -64'sd32768) q = -64'sd32768;
    return q[15:0];
  endfunction

  function automatic curve_point_t eval_curve_point(tparam_t t_raw);
    int unsigned  n;
    tparam_t      t;
    coord_t       wx [MAX_POINTS];
    coord_t       wy [MAX_POINTS];
    curve_point_t p;
    n = point_count;
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    t = (t_raw > T_ONE) ? T_ONE : t_raw;
    for (int i = 0; i < n; i++) begin
      wx[i] = ctrl_x[i];
      wy[i] = ctrl_y[i];
    end
    for (int r = n - 1; r > 0; r--) begin
      for (int i = 0; i < r; i++) begin
        wx[i] = lerp_coord(wx[i], wx[i+1], t);
        wy[i] = lerp_coord(wy[i], wy[i+1], t);
      end
    end
    p.x = wx[0];
    p.y = wy[0];
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    curve_point_t seen;
    curve_point_t due;
    if (!rst_ni) begin
      point_count = POINT_COUNT_RESET;
      curve_points_due.delete();
    end else begin
      if (cfg_we_i) point_count = cfg_wdata_i;
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (in_mon_i.mode == MODE_LOAD) begin
          ctrl_x[in_mon_i.point_index] = in_mon_i.point_x;
          ctrl_y[in_mon_i.point_index] = in_mon_i.point_y;
        end else begin
          curve_points_due.insert(curve_points_due.size(),
                                  eval_curve_point(in_mon_i.t_value));
        end
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        seen.x = out_mon_i.curve_x;
        seen.y = out_mon_i.curve_y;
        if (curve_points_due.size() == 0) begin
          mismatches++;
          $display("%0t: curve point (%0d, %0d) with none expected", $time,
                   $signed(seen.x), $signed(seen.y));
        end else begin
          due = curve_points_due.pop_front();
          if (seen.x !== due.x) begin
            mismatches++;
            $display("%0t: curve_x mismatch: expected %0d, got %0d", $time,
                     $signed(due.x), $signed(seen.x));
          end
          if (seen.y !== due.y) begin
            mismatches++;
            $display("%0t: curve_y mismatch: expected %0d, got %0d", $time,
                     $signed(due.y), $signed(seen.y));
          end
        end
      end
    end
    due_count = curve_points_due.size();
  end

endmodule

// File: bench/bezier_point_evaluator_core_test.sv
`timescale 1ns / 1ps
// bezier_point_evaluator_core_test: drives loads, evaluates and point-count writes
// into the evaluator with random idling on both channels and gives the verdict
// depends on bpe_pkg, bpe_in_if, bpe_out_if, the core and the checker

module bezier_point_evaluator_core_test
  import bpe_pkg::*;
();

  localparam int unsigned MAX_POINTS   = 16;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned PHASES       = 30;
  localparam int unsigned PHASE_ITEMS  = 64;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  count_t      cfg_wdata;
  int unsigned fail_count;
  int unsigned points_due;

  bit          calm      = 1'b0;
  bit          rushing   = 1'b0;
  bit          hold_req  = 1'b0;
  int unsigned loads_sent    = 0;
  int unsigned evals_sent    = 0;
  int unsigned settings_used = 0;

  bpe_in_if  in_ch ();
  bpe_out_if out_ch ();

  bezier_point_evaluator_core #(
    .MAX_POINTS (MAX_POINTS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  bezier_point_evaluator_checker #(
    .MAX_POINTS (MAX_POINTS)
  ) scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .points_due_o (points_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(40_000_000);
    $display("timeout with %0d curve points outstanding", points_due);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(15, 50);
    return $urandom_range(1, 3);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 15))
      0, 1:    return 16'h8000;
      2, 3:    return 16'h7fff;
      4:       return 16'h0000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic tparam_t rand_t();
    case ($urandom_range(0, 19))
      0, 1:    return 17'd0;
      2, 3:    return T_ONE;
      4:       return tparam_t'($urandom_range(65537, 131071));
      default: return tparam_t'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic count_t pick_count(int unsigned phase);
    case (phase)
      0:       return 5'd1;
      1:       return 5'd16;
      2:       return 5'd0;
      3:       return 5'd31;
      4:       return 5'd2;
      5:       return 5'd17;
      default: begin
        if ($urandom_range(0, 7) == 0) return count_t'($urandom_range(0, 31));
        return count_t'($urandom_range(1, 16));
      end
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic m, input logic [3:0] idx, input coord_t x,
                           input coord_t y, input tparam_t t);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.point_index <= idx;
    in_ch.point_x     <= x;
    in_ch.point_y     <= y;
    in_ch.t_value     <= t;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (m == MODE_EVAL) evals_sent++;
    else loads_sent++;
  endtask

  task automatic sender_gap();
    int unsigned g;
    if (calm || rushing || $urandom_range(0, 1) == 0) g = 0;
    else g = idle_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_random_item();
    if ($urandom_range(0, 4) < 3) begin
      send_item(MODE_EVAL, 4'($urandom), rand_coord(), rand_coord(), rand_t());
    end else begin
      send_item(MODE_LOAD, 4'($urandom_range(0, 15)), rand_coord(), rand_coord(),
                tparam_t'($urandom));
    end
    sender_gap();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (points_due != 0) @(negedge clk);
  endtask

  task automatic write_point_count(input count_t value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    tparam_t     sweep_t [7];
    int unsigned drain_left;
    sweep_t = '{17'd0, 17'd1, 17'd32768, 17'd65535, T_ONE, 17'd65537, 17'h1ffff};
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_LOAD;
    in_ch.point_index = '0;
    in_ch.point_x     = '0;
    in_ch.point_y     = '0;
    in_ch.t_value     = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // every control point written before any evaluate reads it
    calm = 1'b1;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (i < 4) begin
        send_item(MODE_LOAD, 4'(i), (i % 2) ? 16'h8000 : 16'h7fff,
                  (i % 2) ? 16'h7fff : 16'h8000, 17'h1ffff);
      end else begin
        send_item(MODE_LOAD, 4'(i), rand_coord(), rand_coord(), tparam_t'($urandom));
      end
      sender_gap();
    end
    foreach (sweep_t[k]) begin
      send_item(MODE_EVAL, 4'hf, 16'hffff, 16'h0000, sweep_t[k]);
      sender_gap();
    end
    calm = 1'b0;

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      write_point_count(pick_count(phase));
      calm = (phase == 7);
      if (phase == 3) begin
        rushing  = 1'b1;
        hold_req = 1'b1;
      end
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 12 && i == PHASE_ITEMS / 2) wait_drained();
        send_random_item();
      end
      rushing = 1'b0;
    end
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    drain_left = 20000;
    while (points_due != 0 && drain_left != 0) begin
      @(negedge clk);
      drain_left--;
    end
    repeat (DRAIN_CYCLES * 2) @(negedge clk);

    $display("covered %0d loads and %0d evaluates over %0d point-count writes",
             loads_sent, evals_sent, settings_used);
    $display("counts 0, 1, 2, 16, 17 and 31 included, t from 0 to beyond 1.0");
    if (points_due != 0) $display("%0d curve points never arrived", points_due);
    if (fail_count == 0 && points_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
sv/bpe_pkg.sv
sv/bpe_in_if.sv
sv/bpe_out_if.sv
sv/bpe_cell.sv
sv/bezier_point_evaluator_core.sv
bench/bezier_point_evaluator_checker.sv
bench/bezier_point_evaluator_core_test.sv
